[design/message_fragmenter_defines.svh]
// Assertion macros shared by the message fragmenter RTL.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef MESSAGE_FRAGMENTER_DEFINES_SVH
`define MESSAGE_FRAGMENTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a property while out of reset.
`define MF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define MF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MF_ASSERT(lbl, prop, msg)
`define MF_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[design/msgfrag_pkg.sv]
// Types and constants of the message fragmenter.
// Used by message_fragmenter; depends on nothing.
package msgfrag_pkg;

  localparam int unsigned CfgWidth     = 10;
  localparam int unsigned LenWidth     = 16;
  localparam int unsigned NumWidth     = LenWidth + 1;
  localparam int unsigned DivSteps     = NumWidth;
  localparam int unsigned DivCntWidth  = $clog2(DivSteps);
  localparam int unsigned CntWidth     = 8;

  localparam logic [CfgWidth-1:0] PayloadMin   = CfgWidth'(5);
  localparam logic [CfgWidth-1:0] PayloadReset = CfgWidth'(20);
  localparam logic [CfgWidth-1:0] HeaderBytes  = CfgWidth'(4);

  localparam logic [1:0] HdrSeq   = 2'd0;
  localparam logic [1:0] HdrCount = 2'd1;
  localparam logic [1:0] HdrLenHi = 2'd2;
  localparam logic [1:0] HdrLenLo = 2'd3;

  typedef struct packed {
    logic [7:0]          data_byte;
    logic [LenWidth-1:0] message_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_end;
    logic       message_end;
    logic       too_large;
  } out_item_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV   = 6'b000010,
    S_ERR   = 6'b000100,
    S_ROUTE = 6'b001000,
    S_HDR   = 6'b010000,
    S_DATA  = 6'b100000
  } state_e;

endpackage

[design/message_fragmenter.sv]
// Message fragmenter top level: sequencer, restoring divider, output register.
// Depends on msgfrag_pkg and message_fragmenter_defines.svh.
//
// Usage: message bytes enter on the in channel (valid/ready), one item per byte;
// message_length is read on the first byte of each message (0 counts as 1).
// Result bytes leave on the out channel (valid/ready) through one output register.
// payload_size is to be written through cfg_we_i/cfg_wdata_i only while the block is
// idle; the block itself does not enforce this. A message no longer than payload_size
// passes through as one packet. A longer one is cut into fragments of payload_size-4
// bytes, each led by a 4-byte header (sequence, fragment count, length high, length low).
// Only one input item is in flight at a time. A plain byte passes IDLE, ROUTE and DATA
// on its way into the output register; a byte that opens a fragment also passes HDR
// for the header; the first byte of a fragmented message first runs the bit-serial
// division in DIV that sets the fragment count. A message over 255 fragments
// yields one too_large item and its bytes are discarded.
// When the receiver stalls in ERR, HDR or DATA, the sequencer holds and in_ready_o stays low.
// Reset clears all message state and sets payload_size to 20.
`include "message_fragmenter_defines.svh"

module message_fragmenter import msgfrag_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 512
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_item_o,
  input  logic                cfg_we_i,
  input  logic [CfgWidth-1:0] cfg_wdata_i
);

  state_e                 state_q, state_d;
  logic [CfgWidth-1:0]    cfg_q, cfg_d;
  logic [LenWidth-1:0]    seen_q, seen_d;
  logic [LenWidth-1:0]    saved_q, saved_d;
  logic [CfgWidth-1:0]    fill_q, fill_d;
  logic [CntWidth-1:0]    seq_q, seq_d;
  logic [CntWidth-1:0]    cnt_q, cnt_d;
  logic                   pass_q, pass_d;
  logic                   drop_q, drop_d;
  logic [1:0]             hdr_q, hdr_d;
  logic [DivCntWidth-1:0] div_cnt_q, div_cnt_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_q, out_d;
  logic [7:0]             byte_q, byte_d;
  logic [NumWidth-1:0]    num_q, num_d;
  logic [CfgWidth-1:0]    rem_q, rem_d;

  logic [CfgWidth-1:0]    p_eff;
  logic [CfgWidth-1:0]    frag;
  logic                   in_fire;
  logic                   slot_free;
  logic [LenWidth-1:0]    len_in;
  logic                   last;
  logic [CfgWidth-1:0]    fill_inc;
  logic                   pkt_end;
  logic [CfgWidth:0]      trial;
  logic                   trial_ge;
  logic [NumWidth-1:0]    quot;
  logic [7:0]             hdr_byte;

  always_comb begin
    p_eff = cfg_q;
    if (cfg_q < PayloadMin) begin
      p_eff = PayloadMin;
    end else if ({1'b0, cfg_q} > (CfgWidth+1)'(MAX_PAYLOAD)) begin
      p_eff = CfgWidth'(MAX_PAYLOAD);
    end
  end

  assign frag      = p_eff - HeaderBytes;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire   = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;
  assign len_in    = (in_item_i.message_length == '0) ? LenWidth'(1)
                                                      : in_item_i.message_length;
  assign last      = ({1'b0, seen_q} + (LenWidth+1)'(1)) >= {1'b0, saved_q};
  assign fill_inc  = fill_q + CfgWidth'(1);
  assign pkt_end   = last || (fill_inc >= frag);

  assign trial    = {rem_q, num_q[NumWidth-1]};
  assign trial_ge = trial >= {1'b0, frag};
  assign quot     = {num_q[NumWidth-2:0], trial_ge};

  always_comb begin
    case (hdr_q)
      HdrSeq:   hdr_byte = seq_q;
      HdrCount: hdr_byte = cnt_q;
      HdrLenHi: hdr_byte = saved_q[15:8];
      HdrLenLo: hdr_byte = saved_q[7:0];
      default:  hdr_byte = '0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    cfg_d       = cfg_we_i ? cfg_wdata_i : cfg_q;
    seen_d      = seen_q;
    saved_d     = saved_q;
    fill_d      = fill_q;
    seq_d       = seq_q;
    cnt_d       = cnt_q;
    pass_d      = pass_q;
    drop_d      = drop_q;
    hdr_d       = hdr_q;
    div_cnt_d   = div_cnt_q;
    byte_d      = byte_q;
    num_d       = num_q;
    rem_d       = rem_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          byte_d  = in_item_i.data_byte;
          state_d = S_ROUTE;
          if (seen_q == '0) begin
            saved_d = len_in;
            fill_d  = '0;
            seq_d   = '0;
            cnt_d   = '0;
            drop_d  = 1'b0;
            pass_d  = len_in <= {{(LenWidth-CfgWidth){1'b0}}, p_eff};
            if (!(len_in <= {{(LenWidth-CfgWidth){1'b0}}, p_eff})) begin
              num_d     = NumWidth'(len_in) + NumWidth'(frag) - NumWidth'(1);
              rem_d     = '0;
              div_cnt_d = '0;
              state_d   = S_DIV;
            end
          end
        end
      end
      S_DIV: begin
        rem_d     = trial_ge ? CfgWidth'(trial - {1'b0, frag}) : trial[CfgWidth-1:0];
        num_d     = quot;
        div_cnt_d = div_cnt_q + DivCntWidth'(1);
        if (div_cnt_q == DivCntWidth'(DivSteps - 1)) begin
          if (|quot[NumWidth-1:CntWidth]) begin
            drop_d  = 1'b1;
            state_d = S_ERR;
          end else begin
            cnt_d   = quot[CntWidth-1:0];
            state_d = S_ROUTE;
          end
        end
      end
      S_ERR: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = '{out_byte: 8'd0, packet_end: 1'b0, message_end: 1'b0,
                          too_large: 1'b1};
          state_d     = S_ROUTE;
        end
      end
      S_ROUTE: begin
        if (drop_q) begin
          seen_d  = seen_q + LenWidth'(1);
          state_d = S_IDLE;
          if (last) begin
            seen_d = '0;
            fill_d = '0;
            seq_d  = '0;
            pass_d = 1'b0;
            drop_d = 1'b0;
          end
        end else if (!pass_q && fill_q == '0) begin
          hdr_d   = HdrSeq;
          state_d = S_HDR;
        end else begin
          state_d = S_DATA;
        end
      end
      S_HDR: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = '{out_byte: hdr_byte, packet_end: 1'b0, message_end: 1'b0,
                          too_large: 1'b0};
          hdr_d       = hdr_q + 2'd1;
          if (hdr_q == HdrLenLo) begin
            state_d = S_DATA;
          end
        end
      end
      S_DATA: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          seen_d      = seen_q + LenWidth'(1);
          state_d     = S_IDLE;
          if (pass_q) begin
            out_d = '{out_byte: byte_q, packet_end: last, message_end: last,
                      too_large: 1'b0};
          end else begin
            out_d  = '{out_byte: byte_q, packet_end: pkt_end, message_end: last,
                       too_large: 1'b0};
            fill_d = fill_inc;
            if (pkt_end) begin
              fill_d = '0;
              seq_d  = seq_q + CntWidth'(1);
            end
          end
          if (last) begin
            seen_d = '0;
            fill_d = '0;
            seq_d  = '0;
            pass_d = 1'b0;
            drop_d = 1'b0;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_q       <= PayloadReset;
      seen_q      <= '0;
      saved_q     <= '0;
      fill_q      <= '0;
      seq_q       <= '0;
      cnt_q       <= '0;
      pass_q      <= 1'b0;
      drop_q      <= 1'b0;
      hdr_q       <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cfg_q       <= cfg_d;
      seen_q      <= seen_d;
      saved_q     <= saved_d;
      fill_q      <= fill_d;
      seq_q       <= seq_d;
      cnt_q       <= cnt_d;
      pass_q      <= pass_d;
      drop_q      <= drop_d;
      hdr_q       <= hdr_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    byte_q <= byte_d;
    num_q  <= num_d;
    rem_q  <= rem_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `MF_ASSERT(a_accept_starts_work, in_fire |=> (state_q == S_ROUTE || state_q == S_DIV), "accepted item did not start work")
  `MF_ASSERT(a_drop_not_pass, drop_q |-> !pass_q, "dropping and pass-through both set")
  `MF_ASSERT(a_hdr_idle, (state_q != S_HDR) |-> (hdr_q == HdrSeq), "header index left nonzero outside header state")
  `MF_ASSERT(a_div_bound, (state_q == S_DIV) |-> (div_cnt_q <= DivCntWidth'(DivSteps - 1)), "divider step count overran")
  `MF_ASSERT_ALWAYS(a_err_clean, (out_valid_o && out_item_o.too_large) |-> (!out_item_o.packet_end && !out_item_o.message_end), "too_large item carries end flags")

endmodule
